// File: src/oabs_pkg.sv
// Shared types and constants for the order-agnostic binary search block.
package oabs_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int CNT_W     = 11;
    localparam int SLOT_W    = 10;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 10;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code                 cmd;
        logic [SLOT_W-1:0]         slot;
        logic signed [VAL_W-1:0]   value;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
    } t_result;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ONE,
        RD_MID
    } t_rd_sel;

    typedef struct packed {
        logic    wr_en;
        logic    take_key;
        t_rd_sel rd_sel;
        logic    latch_e0;
        logic    init_order;
        logic    set_mid;
        logic    step;
        logic    res_set;
        logic    res_found;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic range_ok;
        logic eq;
    } t_dp_sts;

endpackage

// File: src/oabs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oabs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/oabs_dp.sv
// Search datapath: element store, key, bounds, midpoint and result register.
module oabs_dp
    import oabs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  t_item            i_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output t_result          o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;

    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_e0;
    logic                    r_asc;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_end;
    logic [CW-1:0]           r_mid;
    t_result                 r_result;

    logic [VAL_W-1:0]        rdata;
    logic signed [VAL_W-1:0] rdata_s;
    logic [CW-1:0]           n_sat;
    logic [CW-1:0]           diff;
    logic [CW-1:0]           mid;
    logic [AW-1:0]           raddr;
    logic                    wr_ok;
    logic                    key_less;

    assign rdata_s  = $signed(rdata);
    assign n_sat    = (NW'(r_count) > NW'(DEPTH)) ? CW'(DEPTH) : CW'(r_count);
    assign diff     = r_end - r_lo - CW'(1);
    assign mid      = r_lo + (diff >> 1);
    assign wr_ok    = i_cmd.wr_en && (NW'(i_item.slot) < NW'(DEPTH));
    assign key_less = r_key < rdata_s;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ZERO: raddr = '0;
            RD_ONE:  raddr = AW'(1);
            RD_MID:  raddr = AW'(mid);
            default: raddr = '0;
        endcase
    end

    oabs_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_ok),
        .i_waddr(AW'(i_item.slot)),
        .i_wdata(i_item.value),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_wr) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_key) begin
            r_key <= i_item.value;
            r_end <= n_sat;
            r_mid <= '0;
        end
        if (i_cmd.latch_e0) begin
            r_e0 <= rdata_s;
        end
        if (i_cmd.init_order) begin
            r_asc <= r_e0 < rdata_s;
            r_lo  <= '0;
        end
        if (i_cmd.set_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.step) begin
            if (key_less == r_asc) begin
                r_end <= r_mid;
            end else begin
                r_lo <= r_mid + CW'(1);
            end
        end
        if (i_cmd.res_set) begin
            r_result.found    <= i_cmd.res_found;
            r_result.position <= i_cmd.res_found ? POS_W'(r_mid) : '0;
        end
    end

    assign o_sts.n_zero   = (r_end == '0);
    assign o_sts.n_one    = (r_end == CW'(1));
    assign o_sts.range_ok = (r_lo < r_end);
    assign o_sts.eq       = (rdata_s == r_key);
    assign o_result       = r_result;

endmodule

// File: src/oabs_ctrl.sv
// Search controller: sequences order check and midpoint probes.
module oabs_ctrl
    import oabs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_cmd_code i_cmd_code,
    input  t_dp_sts   i_sts,
    output logic      o_busy,
    output logic      o_strobe,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_E0,
        S_E1,
        S_PROBE,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = '0;
        o_cmd.rd_sel = RD_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd_code == CMD_SEARCH) begin
                        o_cmd.take_key = 1'b1;
                        n_state        = S_CHK;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_CHK: begin
                if (i_sts.n_zero) begin
                    o_cmd.res_set = 1'b1;
                    n_strobe      = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_ZERO;
                    n_state      = S_E0;
                end
            end
            S_E0: begin
                o_cmd.latch_e0 = 1'b1;
                if (i_sts.n_one) begin
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_found = i_sts.eq;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_ONE;
                    n_state      = S_E1;
                end
            end
            S_E1: begin
                o_cmd.init_order = 1'b1;
                n_state          = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.range_ok) begin
                    o_cmd.rd_sel  = RD_MID;
                    o_cmd.set_mid = 1'b1;
                    n_state       = S_CMP;
                end else begin
                    o_cmd.res_set = 1'b1;
                    n_strobe      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_CMP: begin
                if (i_sts.eq) begin
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// File: src/order_agnostic_binary_search.sv
// Search over a stored sorted array; a load transfer writes without busy or result.
// Search: an order check (states CHK, E0, E1), then a probe per step (address, then
// registered RAM read), plus a final range check when the range runs out. A count
// of 0 or 1 ends the search early. The result strobe is high in the first cycle
// that busy is low, and a new search can transfer in that cycle.
// Synchronous active-low reset clears the controller and element count; stored
// elements are not cleared.
module order_agnostic_binary_search
    import oabs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output t_result          o_result,
    output logic             o_result_strobe,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = ~busy;

    oabs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd_code(i_item.cmd),
        .i_sts     (dp_sts),
        .o_busy    (busy),
        .o_strobe  (o_result_strobe),
        .o_cmd     (dp_cmd)
    );

    oabs_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (i_cfg_valid & o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_item    (i_item),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_result  (o_result)
    );

endmodule

// File: src/oabs_chk.sv
// Port-level checker for the binary search block, with its bind.
module oabs_chk
    import oabs_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input t_result o_result,
    input logic    o_result_strobe
);

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_SEARCH) |=> busy)
        else $error("search transfer did not raise busy");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_LOAD) |=> (!busy && !o_result_strobe))
        else $error("load transfer started work or produced a result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.found) |-> (o_result.position == '0))
        else $error("not-found result with nonzero position");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

endmodule

bind order_agnostic_binary_search oabs_chk u_oabs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result       (o_result),
    .o_result_strobe(o_result_strobe)
);
